// ----- hdl/prc_pkg.sv -----
// Shared types and constants for the point rotation pipeline.
// No dependencies; imported by every module of the block.
package prc_pkg;

   // Extra fraction bits carried through the rotation
   localparam int GUARD        = 8;
   // One pipeline cell per micro-rotation
   localparam int CORDIC_ITERS = 28;
   // Angle accumulator: units of 2^-32 turn, plus headroom
   localparam int ANGLE_FRAC   = 32;
   localparam int Z_WIDTH      = 34;
   // Gain compensation factor, unsigned Q0.24
   localparam int GAIN_WIDTH   = 24;
   localparam int GAIN_FRAC    = 24;
   localparam logic [GAIN_WIDTH-1:0] GAIN_Q24 = 24'd10188014;
   // Low part of the magnitude that is scaled in one partial product
   localparam int LO_WIDTH     = GAIN_FRAC + GUARD;

   // Arctangent of 2^-i in units of 2^-32 turn, rounded
   localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5
   };

   typedef enum logic [1:0] {
      PLANE_XY   = 2'd0,
      PLANE_YZ   = 2'd1,
      PLANE_ZX   = 2'd2,
      PLANE_PASS = 2'd3
   } plane_type;

   // Control that travels with each item from stage to stage
   typedef struct packed {
      logic      valid;
      plane_type plane;
   } ctl_type;

endpackage

// ----- hdl/point_rotate_about_center.sv -----
// Top level of the point rotation pipeline: prep cell, CORDIC cell chain,
// gain and saturation stages. Uses prc_pkg, prc_prep, prc_cell, prc_scale.
//
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_stall  | func, point, center, turn_angle
//   rsp_     | out       | rsp_valid/rsp_stall  | rotated_x/y/z, saturated
//
// Takes one item per cycle unless a response stall backs up the chain. Stages:
// one prep cell, one per micro-rotation (28), four gain/round/saturate.
// Reset clears the valid bit of every stage; payload registers are not reset.
// Each stage holds only while it is occupied and its successor holds, so a
// stalled result lets earlier items close up the empty stages behind it.
module point_rotate_about_center import prc_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_func,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_z,
   input  logic [ANGLE_WIDTH-1:0]        req_turn_angle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_x,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_y,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_z,
   output logic                          rsp_saturated
);

   localparam int DW     = COORD_WIDTH + GUARD + 4;
   localparam int SIDE_W = 5 * COORD_WIDTH;

   ctl_type                   ctl_pipe  [CORDIC_ITERS+1];
   logic signed [DW-1:0]      a_pipe    [CORDIC_ITERS+1];
   logic signed [DW-1:0]      b_pipe    [CORDIC_ITERS+1];
   logic signed [Z_WIDTH-1:0] z_pipe    [CORDIC_ITERS+1];
   logic [SIDE_W-1:0]         side_pipe [CORDIC_ITERS+1];
   logic                      rdy_pipe  [CORDIC_ITERS+1];

   prc_prep #(
      .COORD_WIDTH (COORD_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH),
      .DW          (DW)
   ) u_prep (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_center_z   (req_center_z),
      .req_turn_angle (req_turn_angle),
      .ready_in       (rdy_pipe[0]),
      .ctl_out        (ctl_pipe[0]),
      .a_out          (a_pipe[0]),
      .b_out          (b_pipe[0]),
      .z_out          (z_pipe[0]),
      .side_out       (side_pipe[0])
   );

   for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_cell
      prc_cell #(
         .DW     (DW),
         .SIDE_W (SIDE_W),
         .STAGE  (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl_in    (ctl_pipe[k]),
         .a_in      (a_pipe[k]),
         .b_in      (b_pipe[k]),
         .z_in      (z_pipe[k]),
         .side_in   (side_pipe[k]),
         .ready_out (rdy_pipe[k]),
         .ctl_out   (ctl_pipe[k+1]),
         .a_out     (a_pipe[k+1]),
         .b_out     (b_pipe[k+1]),
         .z_out     (z_pipe[k+1]),
         .side_out  (side_pipe[k+1]),
         .ready_in  (rdy_pipe[k+1])
      );
   end

   prc_scale #(
      .COORD_WIDTH (COORD_WIDTH),
      .DW          (DW)
   ) u_scale (
      .clock         (clock),
      .reset         (reset),
      .ctl_in        (ctl_pipe[CORDIC_ITERS]),
      .a_in          (a_pipe[CORDIC_ITERS]),
      .b_in          (b_pipe[CORDIC_ITERS]),
      .side_in       (side_pipe[CORDIC_ITERS]),
      .ready_out     (rdy_pipe[CORDIC_ITERS]),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y),
      .rsp_rotated_z (rsp_rotated_z),
      .rsp_saturated (rsp_saturated)
   );

   // An accepted item lands in the prep cell
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ctl_pipe[0].valid)
      else $error("accepted item missing from prep cell");

   // Stall the input only when the prep cell holds an item
   a_stall_occupied: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ctl_pipe[0].valid)
      else $error("input stalled with an empty prep cell");

   // The last cell keeps its item while the scaler is full
   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      ctl_pipe[CORDIC_ITERS].valid && !rdy_pipe[CORDIC_ITERS] |=>
         ctl_pipe[CORDIC_ITERS].valid && $stable(a_pipe[CORDIC_ITERS]))
      else $error("last CORDIC cell dropped an item under stall");

endmodule

// ----- hdl/prc_prep.sv -----
// Front cell: picks the plane axes, forms the scaled offsets, applies the
// exact quarter-turn pre-rotation and the residual angle. Uses prc_pkg.
module prc_prep import prc_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16,
   parameter int DW          = COORD_WIDTH + GUARD + 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_func,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_z,
   input  logic [ANGLE_WIDTH-1:0]        req_turn_angle,
   input  logic                          ready_in,
   output ctl_type                       ctl_out,
   output logic signed [DW-1:0]          a_out,
   output logic signed [DW-1:0]          b_out,
   output logic signed [Z_WIDTH-1:0]     z_out,
   output logic [5*COORD_WIDTH-1:0]      side_out
);

   localparam int CW = COORD_WIDTH;
   localparam int AW = ANGLE_WIDTH;

   ctl_type                  ctl_ff, ctl_in;
   logic signed [DW-1:0]     a_ff, a_in, b_ff, b_in;
   logic signed [Z_WIDTH-1:0] z_ff, z_in;
   logic [5*CW-1:0]          side_ff, side_in;
   logic                     ready;

   logic signed [CW-1:0]     pa, ca, pb, cb;
   logic signed [CW-1:0]     a_plus, a_minus, b_plus, b_minus;
   logic signed [CW:0]       diff_a, diff_b;
   logic [AW-1:0]            ang_sum, res;
   logic [1:0]               quad;
   plane_type                plane;

   assign ready     = !ctl_ff.valid || ready_in;
   assign req_stall = !ready;
   assign plane     = plane_type'(req_func);

   always_comb begin
      case (plane)
         PLANE_YZ: begin
            pa = req_point_y;  ca = req_center_y;
            pb = req_point_z;  cb = req_center_z;
         end
         PLANE_ZX: begin
            pa = req_point_x;  ca = req_center_x;
            pb = req_point_z;  cb = req_center_z;
         end
         default: begin
            pa = req_point_x;  ca = req_center_x;
            pb = req_point_y;  cb = req_center_y;
         end
      endcase

      // Round the angle to the nearest quarter turn, keep the residual
      ang_sum = req_turn_angle + AW'(1 << (AW - 3));
      quad    = ang_sum[AW-1:AW-2];
      res     = {req_turn_angle[AW-1:AW-2] - quad, req_turn_angle[AW-3:0]};

      // Clockwise quarter turns as operand swaps of one subtract per axis
      case (quad)
         2'd1: begin
            a_plus = pb;  a_minus = cb;  b_plus = ca;  b_minus = pa;
         end
         2'd2: begin
            a_plus = ca;  a_minus = pa;  b_plus = cb;  b_minus = pb;
         end
         2'd3: begin
            a_plus = cb;  a_minus = pb;  b_plus = pa;  b_minus = ca;
         end
         default: begin
            a_plus = pa;  a_minus = ca;  b_plus = pb;  b_minus = cb;
         end
      endcase

      diff_a  = (CW+1)'(a_plus) - (CW+1)'(a_minus);
      diff_b  = (CW+1)'(b_plus) - (CW+1)'(b_minus);
      a_in    = {{(DW-CW-1-GUARD){diff_a[CW]}}, diff_a, {GUARD{1'b0}}};
      b_in    = {{(DW-CW-1-GUARD){diff_b[CW]}}, diff_b, {GUARD{1'b0}}};
      z_in    = Z_WIDTH'($signed(res)) <<< (ANGLE_FRAC - AW);

      ctl_in.valid = req_valid;
      ctl_in.plane = plane;
      side_in      = {req_point_z, req_point_y, req_point_x, cb, ca};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (ready) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         z_ff    <= z_in;
         side_ff <= side_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign a_out    = a_ff;
   assign b_out    = b_ff;
   assign z_out    = z_ff;
   assign side_out = side_ff;

endmodule

// ----- hdl/prc_cell.sv -----
// One CORDIC micro-rotation cell of the rotation chain.
// Uses prc_pkg for the arctangent table and the control struct.
module prc_cell import prc_pkg::*; #(
   parameter int DW     = 44,
   parameter int SIDE_W = 160,
   parameter int STAGE  = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_type                   ctl_in,
   input  logic signed [DW-1:0]      a_in,
   input  logic signed [DW-1:0]      b_in,
   input  logic signed [Z_WIDTH-1:0] z_in,
   input  logic [SIDE_W-1:0]         side_in,
   output logic                      ready_out,
   output ctl_type                   ctl_out,
   output logic signed [DW-1:0]      a_out,
   output logic signed [DW-1:0]      b_out,
   output logic signed [Z_WIDTH-1:0] z_out,
   output logic [SIDE_W-1:0]         side_out,
   input  logic                      ready_in
);

   ctl_type                   ctl_ff;
   logic signed [DW-1:0]      a_ff, a_in_nxt, b_ff, b_in_nxt;
   logic signed [Z_WIDTH-1:0] z_ff, z_in_nxt;
   logic [SIDE_W-1:0]         side_ff;
   logic signed [DW-1:0]      sa, sb;
   logic signed [Z_WIDTH-1:0] step;
   logic                      ready;

   assign ready     = !ctl_ff.valid || ready_in;
   assign ready_out = ready;

   always_comb begin
      sa   = a_in >>> STAGE;
      sb   = b_in >>> STAGE;
      step = Z_WIDTH'(ATAN_TURN[STAGE]);
      // Turn clockwise while residual angle is non-negative
      if (!z_in[Z_WIDTH-1]) begin
         a_in_nxt = a_in + sb;
         b_in_nxt = b_in - sa;
         z_in_nxt = z_in - step;
      end else begin
         a_in_nxt = a_in - sb;
         b_in_nxt = b_in + sa;
         z_in_nxt = z_in + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (ready) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         a_ff    <= a_in_nxt;
         b_ff    <= b_in_nxt;
         z_ff    <= z_in_nxt;
         side_ff <= side_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign a_out    = a_ff;
   assign b_out    = b_ff;
   assign z_out    = z_ff;
   assign side_out = side_ff;

endmodule

// ----- hdl/prc_scale.sv -----
// Gain compensation, recentering and saturation, four stages ending in the
// result register. Uses prc_pkg for the gain constant and control struct.
module prc_scale import prc_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int DW          = COORD_WIDTH + GUARD + 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctl_type                       ctl_in,
   input  logic signed [DW-1:0]          a_in,
   input  logic signed [DW-1:0]          b_in,
   input  logic [5*COORD_WIDTH-1:0]      side_in,
   output logic                          ready_out,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_x,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_y,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_z,
   output logic                          rsp_saturated
);

   localparam int CW   = COORD_WIDTH;
   localparam int MAGW = (DW > LO_WIDTH + 1) ? DW : LO_WIDTH + 1;
   localparam int HIW  = MAGW - LO_WIDTH;
   localparam int PLW  = LO_WIDTH + GAIN_WIDTH;
   localparam int PHW  = HIW + GAIN_WIDTH;
   localparam int RMW  = PHW + 1;
   localparam int SW   = RMW + 2;
   localparam int SIDE = 5 * CW;

   // Stage 1: sign and magnitude
   ctl_type          ctl1_ff;
   logic             neg_a1_ff, neg_b1_ff;
   logic [MAGW-1:0]  mag_a_ff, mag_b_ff, mag_a_in, mag_b_in;
   logic [SIDE-1:0]  side1_ff;
   logic [DW-1:0]    abs_a, abs_b;
   // Stage 2: partial products with the gain
   ctl_type          ctl2_ff;
   logic             neg_a2_ff, neg_b2_ff;
   logic [PLW-1:0]   plo_a_ff, plo_b_ff, plo_a_in, plo_b_in;
   logic [PHW-1:0]   phi_a_ff, phi_b_ff, phi_a_in, phi_b_in;
   logic [SIDE-1:0]  side2_ff;
   // Stage 3: rounded magnitude
   ctl_type          ctl3_ff;
   logic             neg_a3_ff, neg_b3_ff;
   logic [RMW-1:0]   rm_a_ff, rm_b_ff, rm_a_in, rm_b_in;
   logic [PLW:0]     rnd_a, rnd_b;
   logic [SIDE-1:0]  side3_ff;
   // Stage 4: result register
   logic             rsp_valid_ff;
   plane_type        plane_ff;
   logic signed [CW-1:0] rot_x_ff, rot_y_ff, rot_z_ff, rot_x_in, rot_y_in, rot_z_in;
   logic             sat_ff, sat_in;

   logic             ready1, ready2, ready3, ready4;
   logic signed [CW-1:0] ca, cb, px, py, pz, ra, rb;
   logic signed [SW-1:0] sum_a, sum_b;
   logic             sat_a, sat_b;

   function automatic logic [CW:0] clip(input logic signed [SW-1:0] s);
      logic hi_bits_ok;
      hi_bits_ok = (s[SW-1:CW-1] == {(SW-CW+1){s[SW-1]}});
      if (hi_bits_ok) begin
         return {1'b0, s[CW-1:0]};
      end else if (s[SW-1]) begin
         return {1'b1, 1'b1, {(CW-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(CW-1){1'b1}}};
      end
   endfunction

   assign ready4    = !rsp_valid_ff || !rsp_stall;
   assign ready3    = !ctl3_ff.valid || ready4;
   assign ready2    = !ctl2_ff.valid || ready3;
   assign ready1    = !ctl1_ff.valid || ready2;
   assign ready_out = ready1;

   always_comb begin
      abs_a    = a_in[DW-1] ? DW'(-a_in) : DW'(a_in);
      abs_b    = b_in[DW-1] ? DW'(-b_in) : DW'(b_in);
      mag_a_in = MAGW'(abs_a);
      mag_b_in = MAGW'(abs_b);

      plo_a_in = PLW'(mag_a_ff[LO_WIDTH-1:0]) * PLW'(GAIN_Q24);
      plo_b_in = PLW'(mag_b_ff[LO_WIDTH-1:0]) * PLW'(GAIN_Q24);
      phi_a_in = PHW'(mag_a_ff[MAGW-1:LO_WIDTH]) * PHW'(GAIN_Q24);
      phi_b_in = PHW'(mag_b_ff[MAGW-1:LO_WIDTH]) * PHW'(GAIN_Q24);

      // Round half away from zero: magnitude is rounded, sign applied later
      rnd_a   = (PLW+1)'(plo_a_ff) + ((PLW+1)'(1) << (LO_WIDTH - 1));
      rnd_b   = (PLW+1)'(plo_b_ff) + ((PLW+1)'(1) << (LO_WIDTH - 1));
      rm_a_in = RMW'(phi_a_ff) + RMW'(rnd_a[PLW:LO_WIDTH]);
      rm_b_in = RMW'(phi_b_ff) + RMW'(rnd_b[PLW:LO_WIDTH]);
   end

   always_comb begin
      ca = side3_ff[CW-1:0];
      cb = side3_ff[2*CW-1:CW];
      px = side3_ff[3*CW-1:2*CW];
      py = side3_ff[4*CW-1:3*CW];
      pz = side3_ff[5*CW-1:4*CW];

      sum_a = neg_a3_ff ? SW'(ca) - $signed({2'b00, rm_a_ff})
                        : SW'(ca) + $signed({2'b00, rm_a_ff});
      sum_b = neg_b3_ff ? SW'(cb) - $signed({2'b00, rm_b_ff})
                        : SW'(cb) + $signed({2'b00, rm_b_ff});
      {sat_a, ra} = clip(sum_a);
      {sat_b, rb} = clip(sum_b);

      case (ctl3_ff.plane)
         PLANE_XY: begin
            rot_x_in = ra;  rot_y_in = rb;  rot_z_in = pz;  sat_in = sat_a || sat_b;
         end
         PLANE_YZ: begin
            rot_x_in = px;  rot_y_in = ra;  rot_z_in = rb;  sat_in = sat_a || sat_b;
         end
         PLANE_ZX: begin
            rot_x_in = ra;  rot_y_in = py;  rot_z_in = rb;  sat_in = sat_a || sat_b;
         end
         default: begin
            rot_x_in = px;  rot_y_in = py;  rot_z_in = pz;  sat_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (ready1) ctl1_ff <= ctl_in;
         if (ready2) ctl2_ff <= ctl1_ff;
         if (ready3) ctl3_ff <= ctl2_ff;
         if (ready4) rsp_valid_ff <= ctl3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         neg_a1_ff <= a_in[DW-1];
         neg_b1_ff <= b_in[DW-1];
         mag_a_ff  <= mag_a_in;
         mag_b_ff  <= mag_b_in;
         side1_ff  <= side_in;
      end
      if (ready2) begin
         neg_a2_ff <= neg_a1_ff;
         neg_b2_ff <= neg_b1_ff;
         plo_a_ff  <= plo_a_in;
         plo_b_ff  <= plo_b_in;
         phi_a_ff  <= phi_a_in;
         phi_b_ff  <= phi_b_in;
         side2_ff  <= side1_ff;
      end
      if (ready3) begin
         neg_a3_ff <= neg_a2_ff;
         neg_b3_ff <= neg_b2_ff;
         rm_a_ff   <= rm_a_in;
         rm_b_ff   <= rm_b_in;
         side3_ff  <= side2_ff;
      end
      if (ready4) begin
         plane_ff <= ctl3_ff.plane;
         rot_x_ff <= rot_x_in;
         rot_y_ff <= rot_y_in;
         rot_z_ff <= rot_z_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rotated_x = rot_x_ff;
   assign rsp_rotated_y = rot_y_ff;
   assign rsp_rotated_z = rot_z_ff;
   assign rsp_saturated = sat_ff;

   // A pass-through item never reports clipping
   a_pass_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && plane_ff == PLANE_PASS |-> !sat_ff)
      else $error("pass-through item flagged as saturated");

   // The rounding stage keeps its item while the result register waits
   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      ctl3_ff.valid && !ready4 |=> ctl3_ff.valid && $stable(rm_a_ff) && $stable(rm_b_ff))
      else $error("rounding stage lost an item under stall");

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rot_x_ff) &&
         $stable(rot_y_ff) && $stable(rot_z_ff) && $stable(sat_ff))
      else $error("stalled result changed");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for point_rotate_about_center: directed and random items
// in bursts, checked against a cycle-free predictor of the CORDIC rotation. Depends
// on prc_pkg and the point_rotate_about_center RTL.
module tb_top import prc_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW             = 32;
   localparam int AW             = 16;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int DRAIN_CYCLES   = 50;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic signed [CW-1:0] C_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [CW-1:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [CW-1:0] C_ONE = 32'sh0001_0000;

   typedef struct {
      plane_type            func;
      logic signed [CW-1:0] point_x;
      logic signed [CW-1:0] point_y;
      logic signed [CW-1:0] point_z;
      logic signed [CW-1:0] center_x;
      logic signed [CW-1:0] center_y;
      logic signed [CW-1:0] center_z;
      logic [AW-1:0]        turn_angle;
   } point_item_type;

   typedef struct {
      logic signed [CW-1:0] rotated_x;
      logic signed [CW-1:0] rotated_y;
      logic signed [CW-1:0] rotated_z;
      logic                 saturated;
   } rotated_item_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_func       = '0;
   logic signed [CW-1:0] req_point_x    = '0;
   logic signed [CW-1:0] req_point_y    = '0;
   logic signed [CW-1:0] req_point_z    = '0;
   logic signed [CW-1:0] req_center_x   = '0;
   logic signed [CW-1:0] req_center_y   = '0;
   logic signed [CW-1:0] req_center_z   = '0;
   logic [AW-1:0]        req_turn_angle = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic signed [CW-1:0] rsp_rotated_x;
   logic signed [CW-1:0] rsp_rotated_y;
   logic signed [CW-1:0] rsp_rotated_z;
   logic                 rsp_saturated;

   point_item_type   pending_points[$];
   rotated_item_type expected_rotations[$];
   point_item_type   driven_point;
   int               mismatches  = 0;
   int               idle_cycles = 0;
   int               gap_left    = 0;
   int               burst_left  = 1;
   stall_mode_type   stall_mode  = STALL_NONE;
   int               mode_left   = 0;
   int               stall_period = 2;
   int               stall_phase = 0;

   point_rotate_about_center #(
      .COORD_WIDTH(CW),
      .ANGLE_WIDTH(AW)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_center_z  (req_center_z),
      .req_turn_angle(req_turn_angle),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y),
      .rsp_rotated_z (rsp_rotated_z),
      .rsp_saturated (rsp_saturated)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Multiply by the CORDIC gain in Q0.24 and drop the guard bits,
   // rounding half away from zero.
   function automatic longint apply_gain(longint v);
      logic [63:0] mag, hi, lo, r;
      mag = (v < 0) ? -v : v;
      hi  = mag >> LO_WIDTH;
      lo  = mag & ((64'd1 << LO_WIDTH) - 64'd1);
      r   = hi * GAIN_Q24 + ((lo * GAIN_Q24 + (64'd1 << (LO_WIDTH - 1))) >> LO_WIDTH);
      return (v < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic signed [CW-1:0] clip_coord(longint v, inout logic sat);
      if (v > longint'(C_MAX)) begin
         sat = 1'b1;
         return C_MAX;
      end
      if (v < longint'(C_MIN)) begin
         sat = 1'b1;
         return C_MIN;
      end
      return v[CW-1:0];
   endfunction

   function automatic rotated_item_type rotate_about_center(point_item_type it);
      longint           pnt[3], ctr[3];
      longint           a, b, t, z, sa, sb;
      logic [AW-1:0]    bumped, residue;
      logic [1:0]       quad;
      int               ia, ib;
      logic             sat;
      rotated_item_type o;
      pnt[0] = it.point_x;
      pnt[1] = it.point_y;
      pnt[2] = it.point_z;
      ctr[0] = it.center_x;
      ctr[1] = it.center_y;
      ctr[2] = it.center_z;
      sat = 1'b0;
      o.rotated_x = it.point_x;
      o.rotated_y = it.point_y;
      o.rotated_z = it.point_z;
      if (it.func != PLANE_PASS) begin
         case (it.func)
            PLANE_XY: begin ia = 0; ib = 1; end
            PLANE_YZ: begin ia = 1; ib = 2; end
            default:  begin ia = 0; ib = 2; end
         endcase
         a = (pnt[ia] - ctr[ia]) * (longint'(1) << GUARD);
         b = (pnt[ib] - ctr[ib]) * (longint'(1) << GUARD);
         // Round the angle to the nearest quarter turn, keep the rest for CORDIC
         bumped  = it.turn_angle + (AW'(1) << (AW - 3));
         quad    = bumped[AW-1:AW-2];
         residue = it.turn_angle - (AW'(quad) << (AW - 2));
         z = longint'($signed(residue)) * (longint'(1) << (ANGLE_FRAC - AW));
         case (quad)
            2'd1: begin t = a; a = b; b = -t; end
            2'd2: begin a = -a; b = -b; end
            2'd3: begin t = a; a = -b; b = t; end
            default: ;
         endcase
         for (int i = 0; i < CORDIC_ITERS; i++) begin
            sa = a >>> i;
            sb = b >>> i;
            if (z >= 0) begin
               a = a + sb;
               b = b - sa;
               z = z - longint'({32'd0, ATAN_TURN[i]});
            end else begin
               a = a - sb;
               b = b + sa;
               z = z + longint'({32'd0, ATAN_TURN[i]});
            end
         end
         a = clip_coord(ctr[ia] + apply_gain(a), sat);
         b = clip_coord(ctr[ib] + apply_gain(b), sat);
         if (ia == 0) o.rotated_x = a[CW-1:0];
         else         o.rotated_y = a[CW-1:0];
         if (ib == 1) o.rotated_y = b[CW-1:0];
         else         o.rotated_z = b[CW-1:0];
      end
      o.saturated = sat;
      return o;
   endfunction

   // Random offset of up to about 2^span around base, wrapping at the range ends
   function automatic logic signed [CW-1:0] near_coord(logic signed [CW-1:0] base, int span);
      logic signed [CW-1:0] off;
      off = $signed(CW'($urandom)) >>> (CW - 1 - span);
      return base + off;
   endfunction

   task automatic queue_point(plane_type f, logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                              logic signed [CW-1:0] pz, logic signed [CW-1:0] cx,
                              logic signed [CW-1:0] cy, logic signed [CW-1:0] cz,
                              logic [AW-1:0] ang);
      point_item_type it;
      it.func       = f;
      it.point_x    = px;
      it.point_y    = py;
      it.point_z    = pz;
      it.center_x   = cx;
      it.center_y   = cy;
      it.center_z   = cz;
      it.turn_angle = ang;
      pending_points.push_back(it);
   endtask

   task automatic check_field(string field, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   initial begin : stimulus
      point_item_type       it;
      logic signed [CW-1:0] cx, cy, cz;
      int                   span;
      // Exact quarter turns and the eighth-turn boundaries of the quadrant pick
      queue_point(PLANE_XY, C_ONE, 0, 0, 0, 0, 0, 16'd0);
      queue_point(PLANE_XY, C_ONE, 2 * C_ONE, 0, 0, 0, 0, 16'd16384);
      queue_point(PLANE_XY, C_ONE, 2 * C_ONE, 0, 0, 0, 0, 16'd32768);
      queue_point(PLANE_XY, C_ONE, 2 * C_ONE, 0, 0, 0, 0, 16'd49152);
      queue_point(PLANE_XY, 3 * C_ONE, C_ONE, 7, C_ONE, -C_ONE, 0, 16'd8192);
      queue_point(PLANE_XY, 3 * C_ONE, C_ONE, 7, C_ONE, -C_ONE, 0, 16'd8191);
      queue_point(PLANE_XY, 3 * C_ONE, C_ONE, 7, C_ONE, -C_ONE, 0, 16'd65535);
      queue_point(PLANE_YZ, 5 * C_ONE, 3 * C_ONE, -2 * C_ONE, C_ONE, -C_ONE, 7 * C_ONE, 16'd12345);
      queue_point(PLANE_ZX, 5 * C_ONE, 3 * C_ONE, -2 * C_ONE, C_ONE, -C_ONE, 7 * C_ONE, 16'd40000);
      queue_point(PLANE_YZ, 11, -13, 17, -19, 23, -29, 16'd32767);
      queue_point(PLANE_ZX, 11, -13, 17, -19, 23, -29, 16'd24576);
      // Unused plane selector passes everything through
      queue_point(PLANE_PASS, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 16'd65535);
      queue_point(PLANE_PASS, -1, 0, C_ONE, 0, -1, 0, 16'd8192);
      // Zero offset: point on the center
      queue_point(PLANE_XY, 123456, -654321, 42, 123456, -654321, 0, 16'd1000);
      queue_point(PLANE_YZ, 0, 0, 0, 0, 0, 0, 16'd0);
      queue_point(PLANE_ZX, -1, -1, -1, -1, -1, -1, 16'd65535);
      // Out of range results clip to the ends
      queue_point(PLANE_XY, C_MAX, C_MAX, 0, C_MIN, C_MIN, 0, 16'd8192);
      queue_point(PLANE_YZ, 0, C_MIN, C_MIN, 0, C_MAX, C_MAX, 16'd16384);
      queue_point(PLANE_ZX, C_MAX, 0, C_MIN, 0, 0, 0, 16'd24576);
      queue_point(PLANE_XY, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 16'd0);
      queue_point(PLANE_ZX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 16'd32768);
      queue_point(PLANE_YZ, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, 16'd49151);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         it.func = ($urandom_range(0, 9) == 0) ? PLANE_PASS : plane_type'($urandom_range(0, 2));
         case ($urandom_range(0, 9))
            0, 1: begin
               it.point_x  = $urandom;
               it.point_y  = $urandom;
               it.point_z  = $urandom;
               it.center_x = $urandom;
               it.center_y = $urandom;
               it.center_z = $urandom;
            end
            2: begin
               // Center near an end of the range, point far off: drive saturation
               cx = near_coord($urandom_range(0, 1) ? C_MAX : C_MIN, 20);
               cy = near_coord($urandom_range(0, 1) ? C_MAX : C_MIN, 20);
               cz = near_coord($urandom_range(0, 1) ? C_MAX : C_MIN, 20);
               it.center_x = cx;
               it.center_y = cy;
               it.center_z = cz;
               it.point_x  = near_coord(cx, 30);
               it.point_y  = near_coord(cy, 30);
               it.point_z  = near_coord(cz, 30);
            end
            default: begin
               span = $urandom_range(8, 28);
               cx = near_coord(0, span);
               cy = near_coord(0, span);
               cz = near_coord(0, span);
               span = $urandom_range(0, 26);
               it.center_x = cx;
               it.center_y = cy;
               it.center_z = cz;
               it.point_x  = near_coord(cx, span);
               it.point_y  = near_coord(cy, span);
               it.point_z  = near_coord(cz, span);
            end
         endcase
         if ($urandom_range(0, 4) == 0)
            it.turn_angle = AW'($urandom_range(0, 7) * 8192 + $urandom_range(0, 6) - 3);
         else
            it.turn_angle = $urandom_range(0, 65535);
         pending_points.push_back(it);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_points.size() > 0 || req_valid) @(posedge clock);
      while (expected_rotations.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_rotations.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Sender: bursts of back-to-back items separated by random gaps
   always @(posedge clock) begin : driver
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_rotations.push_back(rotate_about_center(driven_point));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
               driven_point = pending_points.pop_front();
               req_valid      <= 1'b1;
               req_func       <= driven_point.func;
               req_point_x    <= driven_point.point_x;
               req_point_y    <= driven_point.point_y;
               req_point_z    <= driven_point.point_z;
               req_center_x   <= driven_point.center_x;
               req_center_y   <= driven_point.center_y;
               req_center_z   <= driven_point.center_z;
               req_turn_angle <= driven_point.turn_angle;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                           : $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 30)
                                                           : $urandom_range(0, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each item, then advance the stall pattern
   always @(posedge clock) begin : monitor
      rotated_item_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rotations.size() == 0) begin
               $display("%0t ns: unexpected item, expected none, actual x=%0d y=%0d z=%0d sat=%0b",
                        $time, rsp_rotated_x, rsp_rotated_y, rsp_rotated_z, rsp_saturated);
               mismatches++;
            end else begin
               want = expected_rotations.pop_front();
               check_field("rotated_x", want.rotated_x, rsp_rotated_x);
               check_field("rotated_y", want.rotated_y, rsp_rotated_y);
               check_field("rotated_z", want.rotated_z, rsp_rotated_z);
               check_field("saturated", {63'd0, want.saturated}, {63'd0, rsp_saturated});
            end
         end
         if (mode_left == 0) begin
            stall_mode   = stall_mode_type'($urandom_range(0, 3));
            mode_left    = $urandom_range(20, 300);
            stall_period = $urandom_range(2, 9);
            stall_phase  = 0;
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: begin
               rsp_stall   <= (stall_phase >= stall_period / 2);
               stall_phase = (stall_phase + 1) % stall_period;
            end
         endcase
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no item accepted for %0d cycles", $time, idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
